// ===== rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define STCG_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: assertion failed");

// signal holds its value in the cycle after cond
`define STCG_ASSERT_HELD(lbl, clk, rst_n, cond, sig) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
		else $error("%m: value changed while held");

`endif

// ===== rtl/stcg_pkg.sv =====
// ----------------------------------------------------------------------------
// stcg_pkg
// Types and constants of the spherical texture coordinate pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package stcg_pkg;

	localparam logic [31:0] Q30_ONE    = 32'h4000_0000;
	localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;

	// arc cosine polynomial in Q2.30, lowest order first
	localparam logic signed [31:0] ACOS_POLY [8] = '{
		32'sd1686629690, -32'sd230423709, 32'sd95540460, -32'sd53874249,
		32'sd33169905, -32'sd18348235, 32'sd7161955, -32'sd1355590
	};

	typedef enum logic [1:0] {
		CFG_CENTER_X = 2'd0,
		CFG_CENTER_Y = 2'd1,
		CFG_CENTER_Z = 2'd2
	} cfg_idx_t;

	// carried alongside the radius root
	typedef struct packed {
		logic [31:0] my;
		logic [31:0] mz;
		logic        sy;
		logic        sz;
	} rad_side_t;

	// dual-lane restoring divider state
	typedef struct packed {
		logic [31:0] den;
		logic [32:0] rem_z;
		logic [32:0] rem_y;
		logic [30:0] quo_z;
		logic [30:0] quo_y;
		logic        ovf_z;
		logic        ovf_y;
		logic        sz;
		logic        sy;
	} div_t;

	// dual-lane horner state
	typedef struct packed {
		logic signed [32:0] p_z;
		logic signed [32:0] p_y;
		logic [30:0]        q_z;
		logic [30:0]        q_y;
		logic               sz;
		logic               sy;
	} poly_t;

	// carried alongside the second root
	typedef struct packed {
		logic        neg;
		logic [31:0] p;
	} ang_side_t;

endpackage

`default_nettype wire

// ===== rtl/stcg_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// stcg_sqrt_cell
// One digit of a restoring square root, two radicand bits per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module stcg_sqrt_cell #(
	parameter int W = 32,
	parameter type side_t = logic
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           valid_i,
	input  wire logic [2*W-1:0] n_i,
	input  wire logic [W+1:0]   rem_i,
	input  wire logic [W-1:0]   root_i,
	input  side_t               side_i,
	output logic                valid_o,
	output logic [2*W-1:0]      n_o,
	output logic [W+1:0]        rem_o,
	output logic [W-1:0]        root_o,
	output side_t               side_o
);

	logic [W+1:0] cur;
	logic [W+1:0] trial;
	logic         ge;

	assign cur   = {rem_i[W-1:0], n_i[2*W-1:2*W-2]};
	assign trial = {root_i, 2'b01};
	assign ge    = cur >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_o    <= {n_i[2*W-3:0], 2'b00};
			rem_o  <= ge ? cur - trial : cur;
			root_o <= {root_i[W-2:0], ge};
			side_o <= side_i;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/stcg_div_cell.sv =====
// ----------------------------------------------------------------------------
// stcg_div_cell
// One quotient bit of the z and y ratio dividers.
// ----------------------------------------------------------------------------
`default_nettype none

module stcg_div_cell (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    en,
	input  wire logic    valid_i,
	input  stcg_pkg::div_t div_i,
	output logic         valid_o,
	output stcg_pkg::div_t div_o
);

	import stcg_pkg::*;

	logic [32:0] den;
	logic        ge_z;
	logic        ge_y;
	logic [32:0] rz;
	logic [32:0] ry;
	div_t        div_nxt;

	assign den  = {1'b0, div_i.den};
	assign ge_z = div_i.rem_z >= den;
	assign ge_y = div_i.rem_y >= den;
	assign rz   = ge_z ? div_i.rem_z - den : div_i.rem_z;
	assign ry   = ge_y ? div_i.rem_y - den : div_i.rem_y;

	always_comb begin
		div_nxt       = div_i;
		div_nxt.rem_z = {rz[31:0], 1'b0};
		div_nxt.rem_y = {ry[31:0], 1'b0};
		div_nxt.quo_z = {div_i.quo_z[29:0], ge_z};
		div_nxt.quo_y = {div_i.quo_y[29:0], ge_y};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_o <= div_nxt;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/stcg_poly_cell.sv =====
// ----------------------------------------------------------------------------
// stcg_poly_cell
// One horner step of the arc cosine polynomial for both lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module stcg_poly_cell #(
	parameter int IDX = 6
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     en,
	input  wire logic     valid_i,
	input  stcg_pkg::poly_t poly_i,
	output logic          valid_o,
	output stcg_pkg::poly_t poly_o
);

	import stcg_pkg::*;

	logic signed [64:0] prod_z;
	logic signed [64:0] prod_y;
	logic signed [64:0] sh_z;
	logic signed [64:0] sh_y;
	logic signed [32:0] coef;
	poly_t              poly_nxt;

	assign coef   = 33'(ACOS_POLY[IDX]);
	assign prod_z = poly_i.p_z * $signed({1'b0, poly_i.q_z});
	assign prod_y = poly_i.p_y * $signed({1'b0, poly_i.q_y});
	// arithmetic shift floors toward minus infinity
	assign sh_z   = prod_z >>> 30;
	assign sh_y   = prod_y >>> 30;

	always_comb begin
		poly_nxt     = poly_i;
		poly_nxt.p_z = sh_z[32:0] + coef;
		poly_nxt.p_y = sh_y[32:0] + coef;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			poly_o <= poly_nxt;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/spherical_texcoord_generator.sv =====
// ----------------------------------------------------------------------------
// spherical_texcoord_generator
// Projects a vertex onto a sphere around a set center and returns u, v.
// ----------------------------------------------------------------------------
// channel | signals                             | flow
// vtx     | vtx_valid vtx_stall vertex_x/y/z    | in, valid/stall
// tex     | tex_valid tex_stall tex_u tex_v     | out, valid/stall
// cfg     | cfg_valid cfg_ready cfg_index/data  | in, valid/ready, always ready
//
// one vertex per cycle while no result is held at the output
// the pipeline is built from chains of cells: 32 radius root, 31 divide, 7 horner,
// 31 arc root, plus input, squares, sum, divider entry, clamp and output stages
// the whole pipeline moves as one; it halts only while a result is held
// reset clears valid bits and the center registers
`default_nettype none

module spherical_texcoord_generator #(
	parameter int OUT_FRAC_BITS = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     vtx_valid,
	output logic                          vtx_stall,
	input  wire logic signed [31:0]       vertex_x,
	input  wire logic signed [31:0]       vertex_y,
	input  wire logic signed [31:0]       vertex_z,
	output logic                          tex_valid,
	input  wire logic                     tex_stall,
	output logic [OUT_FRAC_BITS:0]        tex_u,
	output logic [OUT_FRAC_BITS:0]        tex_v,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [1:0]               cfg_index,
	input  wire logic [31:0]              cfg_data
);

	import stcg_pkg::*;

	localparam int OUT_W  = OUT_FRAC_BITS + 1;
	localparam int RND_SH = 61 - OUT_FRAC_BITS;
	localparam int OUT_SH = 62 - OUT_FRAC_BITS;
	localparam logic [63:0] ONE64 = 64'd1 << OUT_FRAC_BITS;
	localparam logic [63:0] RND   = 64'd1 << RND_SH;

	logic adv;
	logic [31:0] center_x_q, center_y_q, center_z_q;

	assign adv       = !tex_valid || !tex_stall;
	assign vtx_stall = !adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_CENTER_X: center_x_q <= cfg_data;
				CFG_CENTER_Y: center_y_q <= cfg_data;
				CFG_CENTER_Z: center_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// saturating difference and magnitude
	logic signed [32:0] dx, dy, dz;
	logic signed [31:0] sx, sy, sz;

	assign dx = 33'(vertex_x) - 33'($signed(center_x_q));
	assign dy = 33'(vertex_y) - 33'($signed(center_y_q));
	assign dz = 33'(vertex_z) - 33'($signed(center_z_q));

	function automatic logic signed [31:0] sat32(input logic signed [32:0] d);
		if (d[32] != d[31]) begin
			return d[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
		return d[31:0];
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] d);
		return d[31] ? 32'(-d) : d;
	endfunction

	assign sx = sat32(dx);
	assign sy = sat32(dy);
	assign sz = sat32(dz);

	logic        valid_s1, valid_s2, valid_s3;
	logic [31:0] mx_s1;
	rad_side_t   side_s1, side_s2, side_s3;
	logic [63:0] sqx_s2, sqy_s2, sqz_s2, sum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= vtx_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s1      <= mag32(sx);
			side_s1.my <= mag32(sy);
			side_s1.mz <= mag32(sz);
			side_s1.sy <= sy[31];
			side_s1.sz <= sz[31];
			sqx_s2     <= 64'(mx_s1) * 64'(mx_s1);
			sqy_s2     <= 64'(side_s1.my) * 64'(side_s1.my);
			sqz_s2     <= 64'(side_s1.mz) * 64'(side_s1.mz);
			side_s2    <= side_s1;
			sum_s3     <= sqx_s2 + sqy_s2 + sqz_s2;
			side_s3    <= side_s2;
		end
	end

	// radius root chain
	logic        r1_v    [0:32];
	logic [63:0] r1_n    [0:32];
	logic [33:0] r1_rem  [0:32];
	logic [31:0] r1_root [0:32];
	rad_side_t   r1_side [0:32];

	assign r1_v[0]    = valid_s3;
	assign r1_n[0]    = sum_s3;
	assign r1_rem[0]  = '0;
	assign r1_root[0] = '0;
	assign r1_side[0] = side_s3;

	for (genvar k = 0; k < 32; k++) begin : g_rad
		stcg_sqrt_cell #(.W(32), .side_t(rad_side_t)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.valid_i(r1_v[k]), .n_i(r1_n[k]), .rem_i(r1_rem[k]),
			.root_i(r1_root[k]), .side_i(r1_side[k]),
			.valid_o(r1_v[k+1]), .n_o(r1_n[k+1]), .rem_o(r1_rem[k+1]),
			.root_o(r1_root[k+1]), .side_o(r1_side[k+1])
		);
	end

	// divider entry: floor radius at one lsb, flag quotients of two or more
	logic        valid_s4;
	div_t        div_s4;
	logic [31:0] rad;

	assign rad = (r1_root[32] == '0) ? 32'd1 : r1_root[32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= r1_v[32];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s4.den   <= rad;
			div_s4.rem_z <= {1'b0, r1_side[32].mz};
			div_s4.rem_y <= {1'b0, r1_side[32].my};
			div_s4.quo_z <= '0;
			div_s4.quo_y <= '0;
			div_s4.ovf_z <= {1'b0, r1_side[32].mz} >= {rad, 1'b0};
			div_s4.ovf_y <= {1'b0, r1_side[32].my} >= {rad, 1'b0};
			div_s4.sz    <= r1_side[32].sz;
			div_s4.sy    <= r1_side[32].sy;
		end
	end

	logic dv_v [0:31];
	div_t dv_d [0:31];

	assign dv_v[0] = valid_s4;
	assign dv_d[0] = div_s4;

	for (genvar k = 0; k < 31; k++) begin : g_div
		stcg_div_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.valid_i(dv_v[k]), .div_i(dv_d[k]),
			.valid_o(dv_v[k+1]), .div_o(dv_d[k+1])
		);
	end

	// ratio clamp to one
	logic  valid_s5;
	poly_t poly_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s5 <= dv_v[31];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			poly_s5.p_z <= 33'(ACOS_POLY[7]);
			poly_s5.p_y <= 33'(ACOS_POLY[7]);
			poly_s5.q_z <= (dv_d[31].ovf_z || dv_d[31].quo_z > Q30_ONE[30:0]) ?
				Q30_ONE[30:0] : dv_d[31].quo_z;
			poly_s5.q_y <= (dv_d[31].ovf_y || dv_d[31].quo_y > Q30_ONE[30:0]) ?
				Q30_ONE[30:0] : dv_d[31].quo_y;
			poly_s5.sz  <= dv_d[31].sz;
			poly_s5.sy  <= dv_d[31].sy;
		end
	end

	logic  pl_v [0:7];
	poly_t pl_d [0:7];

	assign pl_v[0] = valid_s5;
	assign pl_d[0] = poly_s5;

	for (genvar k = 0; k < 7; k++) begin : g_poly
		stcg_poly_cell #(.IDX(6 - k)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.valid_i(pl_v[k]), .poly_i(pl_d[k]),
			.valid_o(pl_v[k+1]), .poly_o(pl_d[k+1])
		);
	end

	// sqrt(1 - q) for both lanes, polynomial rides along
	logic        az_v    [0:31];
	logic [61:0] az_n    [0:31];
	logic [32:0] az_rem  [0:31];
	logic [30:0] az_root [0:31];
	ang_side_t   az_side [0:31];
	logic        ay_v    [0:31];
	logic [61:0] ay_n    [0:31];
	logic [32:0] ay_rem  [0:31];
	logic [30:0] ay_root [0:31];
	ang_side_t   ay_side [0:31];
	logic [30:0] omq_z, omq_y;

	assign omq_z = Q30_ONE[30:0] - pl_d[7].q_z;
	assign omq_y = Q30_ONE[30:0] - pl_d[7].q_y;

	assign az_v[0]        = pl_v[7];
	assign az_n[0]        = {1'b0, omq_z, 30'b0};
	assign az_rem[0]      = '0;
	assign az_root[0]     = '0;
	assign az_side[0].neg = pl_d[7].sz;
	assign az_side[0].p   = pl_d[7].p_z[32] ? 32'd0 : pl_d[7].p_z[31:0];
	assign ay_v[0]        = pl_v[7];
	assign ay_n[0]        = {1'b0, omq_y, 30'b0};
	assign ay_rem[0]      = '0;
	assign ay_root[0]     = '0;
	assign ay_side[0].neg = pl_d[7].sy;
	assign ay_side[0].p   = pl_d[7].p_y[32] ? 32'd0 : pl_d[7].p_y[31:0];

	for (genvar k = 0; k < 31; k++) begin : g_arc
		stcg_sqrt_cell #(.W(31), .side_t(ang_side_t)) u_cell_z (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.valid_i(az_v[k]), .n_i(az_n[k]), .rem_i(az_rem[k]),
			.root_i(az_root[k]), .side_i(az_side[k]),
			.valid_o(az_v[k+1]), .n_o(az_n[k+1]), .rem_o(az_rem[k+1]),
			.root_o(az_root[k+1]), .side_o(az_side[k+1])
		);
		stcg_sqrt_cell #(.W(31), .side_t(ang_side_t)) u_cell_y (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.valid_i(ay_v[k]), .n_i(ay_n[k]), .rem_i(ay_rem[k]),
			.root_i(ay_root[k]), .side_i(ay_side[k]),
			.valid_o(ay_v[k+1]), .n_o(ay_n[k+1]), .rem_o(ay_rem[k+1]),
			.root_o(ay_root[k+1]), .side_o(ay_side[k+1])
		);
	end

	// angle, scale by 1/pi, round and fold
	logic        valid_s6, valid_s7;
	logic [62:0] angp_z, angp_y;
	logic [31:0] ang_z_s6, ang_y_s6;
	logic        nz_s6, ny_s6, nz_s7, ny_s7;
	logic [62:0] prd_z_s7, prd_y_s7;
	logic [63:0] t_z, t_y, c_z, c_y;
	logic [OUT_W-1:0] tex_u_q, tex_v_q;
	logic        tex_valid_q;

	assign angp_z = 63'(az_root[31]) * 63'(az_side[31].p);
	assign angp_y = 63'(ay_root[31]) * 63'(ay_side[31].p);

	assign t_z = (64'(prd_z_s7) + RND) >> OUT_SH;
	assign t_y = (64'(prd_y_s7) + RND) >> OUT_SH;
	assign c_z = (t_z > ONE64) ? ONE64 : t_z;
	assign c_y = (t_y > ONE64) ? ONE64 : t_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6    <= 1'b0;
			valid_s7    <= 1'b0;
			tex_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s6    <= az_v[31];
			valid_s7    <= valid_s6;
			tex_valid_q <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ang_z_s6 <= angp_z[61:30];
			ang_y_s6 <= angp_y[61:30];
			nz_s6    <= az_side[31].neg;
			ny_s6    <= ay_side[31].neg;
			prd_z_s7 <= 63'(ang_z_s6) * 63'(INV_PI_Q32);
			prd_y_s7 <= 63'(ang_y_s6) * 63'(INV_PI_Q32);
			nz_s7    <= nz_s6;
			ny_s7    <= ny_s6;
			tex_u_q  <= nz_s7 ? OUT_W'(ONE64 - c_z) : OUT_W'(c_z);
			tex_v_q  <= ny_s7 ? OUT_W'(ONE64 - c_y) : OUT_W'(c_y);
		end
	end

	assign tex_valid = tex_valid_q;
	assign tex_u     = tex_u_q;
	assign tex_v     = tex_v_q;

endmodule

`default_nettype wire

// ===== rtl/stcg_checker.sv =====
// ----------------------------------------------------------------------------
// stcg_checker
// Port-level checks of the texture coordinate generator.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module stcg_checker #(
	parameter int OUT_FRAC_BITS = 16
) (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 vtx_stall,
	input wire logic                 tex_valid,
	input wire logic                 tex_stall,
	input wire logic [OUT_FRAC_BITS:0] tex_u,
	input wire logic [OUT_FRAC_BITS:0] tex_v,
	input wire logic                 cfg_ready
);

	localparam logic [OUT_FRAC_BITS:0] ONE = (OUT_FRAC_BITS + 1)'(1) << OUT_FRAC_BITS;

	`STCG_ASSERT(a_hold_beat, clk, arst_n, tex_valid && tex_stall |=> tex_valid)
	`STCG_ASSERT_HELD(a_hold_u, clk, arst_n, tex_valid && tex_stall, tex_u)
	`STCG_ASSERT(a_free_in, clk, arst_n, !tex_valid || !tex_stall |-> !vtx_stall)
	`STCG_ASSERT(a_u_range, clk, arst_n, tex_valid |-> tex_u <= ONE)
	`STCG_ASSERT(a_v_range, clk, arst_n, tex_valid && cfg_ready |-> tex_v <= ONE)

endmodule

bind spherical_texcoord_generator stcg_checker #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_chk (.*);

`default_nettype wire
